// File: src/mf8_pkg.sv
package mf8_pkg;

  // One operand pair as it arrives on the command port
  typedef struct packed {
    logic [7:0] a_bits;
    logic [7:0] b_bits;
  } operands_t;

  // One encoded sum with its range flags
  typedef struct packed {
    logic [7:0] sum_bits;
    logic       overflow;
    logic       underflow;
  } result_t;

  // Raw sum handed from the alignment adder to the normaliser
  typedef struct packed {
    logic       bypass;       // an operand was zero: pass bypass_bits through
    logic [7:0] bypass_bits;
    logic       sign;
    logic [4:0] exp;          // biased exponent, two's complement
    logic [7:0] sig;          // hidden bit at 6, guard bits at 1:0
  } raw_sum_t;

  localparam logic [7:0] HiddenSig   = 8'h40;
  localparam logic [7:0] RoundUlp    = 8'h04;
  localparam logic [6:0] MaxMagnitude = 7'h7F;
  localparam logic [4:0] ExpFieldMax = 5'd7;
  localparam logic [4:0] ExpFieldMin = 5'd1;

endpackage

// File: src/mf8_align.sv
module mf8_align (
  input  mf8_pkg::operands_t ops_i,
  output mf8_pkg::raw_sum_t  raw_o
);

  logic       a_zero, b_zero, swap;
  logic [2:0] a_exp, b_exp, x_exp, y_exp, shift;
  logic [7:0] a_sig, b_sig, x_sig, y_sig, y_aligned;
  logic       x_neg, y_neg, unlike;
  logic [7:0] x_term, y_term, sum, sum_mag;
  logic       sum_sign;

  assign a_exp  = ops_i.a_bits[6:4];
  assign b_exp  = ops_i.b_bits[6:4];
  assign a_zero = (a_exp == 3'd0);
  assign b_zero = (b_exp == 3'd0);
  assign a_sig  = mf8_pkg::HiddenSig | {2'b00, ops_i.a_bits[3:0], 2'b00};
  assign b_sig  = mf8_pkg::HiddenSig | {2'b00, ops_i.b_bits[3:0], 2'b00};

  // Larger exponent goes to x; on a tie a stays in x
  assign swap  = (b_exp > a_exp);
  assign x_exp = swap ? b_exp : a_exp;
  assign y_exp = swap ? a_exp : b_exp;
  assign x_sig = swap ? b_sig : a_sig;
  assign y_sig = swap ? a_sig : b_sig;
  assign x_neg = swap ? ops_i.b_bits[7] : ops_i.a_bits[7];
  assign y_neg = swap ? ops_i.a_bits[7] : ops_i.b_bits[7];

  assign shift     = x_exp - y_exp;
  assign y_aligned = y_sig >> shift;

  // Negate the negative operand when signs differ
  assign unlike = (x_neg != y_neg);
  assign x_term = (unlike && x_neg) ? (~x_sig + 8'd1) : x_sig;
  assign y_term = (unlike && !x_neg) ? (~y_aligned + 8'd1) : y_aligned;
  assign sum    = x_term + y_term;

  always_comb begin
    sum_mag  = sum;
    sum_sign = x_neg;
    if (unlike) begin
      sum_sign = 1'b0;
      if (sum[7]) begin
        sum_mag  = ~sum + 8'd1;
        sum_sign = 1'b1;
      end
    end
  end

  always_comb begin
    raw_o.bypass      = a_zero || b_zero;
    raw_o.bypass_bits = a_zero ? (b_zero ? 8'h00 : ops_i.b_bits) : ops_i.a_bits;
    raw_o.sign        = sum_sign;
    raw_o.exp         = {2'b00, x_exp};
    raw_o.sig         = sum_mag;
  end

endmodule

// File: src/mf8_norm.sv
module mf8_norm (
  input  mf8_pkg::raw_sum_t raw_i,
  output mf8_pkg::result_t  res_o
);

  function automatic logic [2:0] lead_zeros(input logic [6:0] v);
    logic [2:0] n;
    logic       found;
    n     = 3'd6;
    found = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 3'(6 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic [2:0] lz;
  logic [7:0] norm_sig, rnd_sig, fin_sig;
  logic [4:0] norm_exp, fin_exp;

  assign lz = lead_zeros(raw_i.sig[6:0]);

  always_comb begin
    if (raw_i.sig[7]) begin
      norm_sig = raw_i.sig >> 1;
      norm_exp = raw_i.exp + 5'd1;
    end else begin
      norm_sig = raw_i.sig << lz;
      norm_exp = raw_i.exp - {2'b00, lz};
    end
  end

  // Round up when guard bits are 1x and the kept fraction is odd
  assign rnd_sig = (norm_sig[1] && norm_sig[2]) ? (norm_sig + mf8_pkg::RoundUlp)
                                                : norm_sig;

  always_comb begin
    if (rnd_sig[7]) begin
      fin_sig = rnd_sig >> 1;
      fin_exp = norm_exp + 5'd1;
    end else begin
      fin_sig = rnd_sig;
      fin_exp = norm_exp;
    end
  end

  always_comb begin
    res_o.sum_bits  = 8'h00;
    res_o.overflow  = 1'b0;
    res_o.underflow = 1'b0;
    if (raw_i.bypass) begin
      res_o.sum_bits = raw_i.bypass_bits;
    end else if (raw_i.sig == 8'h00) begin
      res_o.sum_bits = 8'h00;
    end else if ($signed(fin_exp) > $signed(mf8_pkg::ExpFieldMax)) begin
      res_o.sum_bits = {raw_i.sign, mf8_pkg::MaxMagnitude};
      res_o.overflow = 1'b1;
    end else if ($signed(fin_exp) < $signed(mf8_pkg::ExpFieldMin)) begin
      res_o.underflow = 1'b1;
    end else begin
      res_o.sum_bits = {raw_i.sign, fin_exp[2:0], fin_sig[5:2]};
    end
  end

endmodule

// File: src/minifloat8_adder_top.sv
// Eight-bit minifloat adder (sign, 3-bit exponent with bias 4, 4-bit fraction).
// One operand pair is taken in every clock cycle: busy is always low. Each
// transfer gives its result, marked by done_o for one cycle, after it has
// passed the operand register and then the align/add and normalise/round
// logic into the result register. The receiver cannot hold results off and
// must take each one in the cycle it is shown. Overflow saturates to the
// largest magnitude; a nonzero sum below range flushes to zero with
// underflow set.
module minifloat8_adder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mf8_pkg::operands_t operands_i,
  output logic               done_o,
  output mf8_pkg::result_t   result_o
);

  logic               in_vld_q;
  mf8_pkg::operands_t in_q;
  logic               out_vld_q;
  mf8_pkg::result_t   out_q, out_d;
  mf8_pkg::raw_sum_t  raw;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= operands_i;
    end
    if (in_vld_q) begin
      out_q <= out_d;
    end
  end

  mf8_align u_align (
    .ops_i (in_q),
    .raw_o (raw)
  );

  mf8_norm u_norm (
    .raw_i (raw),
    .res_o (out_d)
  );

  assign done_o   = out_vld_q;
  assign result_o = out_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("transfer gave no result two cycles later");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching transfer");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.overflow && result_o.underflow))
    else $error("overflow and underflow both set");

  a_uflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.underflow) |-> (result_o.sum_bits == 8'h00))
    else $error("underflow without flush to zero");

  a_oflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.overflow) |-> (result_o.sum_bits[6:0] == 7'h7F))
    else $error("overflow without saturation");

endmodule
